// ===== sv/four_level_page_table_mapper_defines.svh =====
// Assertion macros used by the checker file
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH

`define FPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpt check failed");

`define FPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpt check failed");

`define FPT_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("fpt reset check failed");

`endif

// ===== sv/fpt_pkg.sv =====
package fpt_pkg;

  localparam int TABLE_COUNT = 64;
  localparam int ENTRIES     = 512;
  localparam int IDX_W       = 9;
  localparam int TBL_W       = $clog2(TABLE_COUNT);
  localparam int ADDR_W      = TBL_W + IDX_W;
  localparam int DEPTH       = TABLE_COUNT * ENTRIES;
  localparam int NF_W        = TBL_W + 1;
  localparam int ENT_W       = 39;
  localparam int BASE_W      = 36;
  localparam int VA_W        = 48;

  localparam logic [1:0] OP_MAP_4K = 2'd0;
  localparam logic [1:0] OP_MAP_2M = 2'd1;
  localparam logic [1:0] OP_MAP_1G = 2'd2;
  localparam logic [1:0] OP_UNMAP  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NO_POOL = 2'd2;

  localparam int ENT_P  = 0;
  localparam int ENT_W_BIT = 1;
  localparam int ENT_PS = 2;
  localparam int ENT_BASE_LSB = 3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } res_t;

endpackage

// ===== sv/four_level_page_table_mapper.sv =====
// Maps or unmaps one page per item over a four-level radix table held in one
// on-chip memory of 64 tables by 512 entries. After reset the memory is
// cleared one entry a cycle, all 32768 entries, with in_stall high. An item
// is accepted in the idle state, then visits each table level in a read
// state (memory read) and an evaluate state (evaluate and write back), and
// its status is handed over from a done state, which waits while the last
// status is still stalled. Each dependent level waits on the registered
// memory read. A new item is taken while the last status waits.
module four_level_page_table_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [47:0] virt_addr,
  input  logic [47:0] phys_addr,
  input  logic        writable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status
);

  fpt_pkg::ram_req_t req;
  fpt_pkg::res_t res;
  logic [fpt_pkg::ENT_W-1:0] rdata;
  logic slot_free;

  assign slot_free = !out_valid || !out_stall;

  fpt_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .virt_addr (virt_addr),
    .phys_addr (phys_addr),
    .writable  (writable),
    .slot_free (slot_free),
    .res       (res),
    .req       (req),
    .rdata     (rdata)
  );

  fpt_ram #(
    .WIDTH (fpt_pkg::ENT_W),
    .DEPTH (fpt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      status <= res.status;
    end
  end

endmodule

// ===== sv/fpt_ram.sv =====
module fpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fpt_walk.sv =====
module fpt_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [fpt_pkg::VA_W-1:0]    virt_addr,
  input  logic [fpt_pkg::VA_W-1:0]    phys_addr,
  input  logic                        writable,
  input  logic                        slot_free,
  output fpt_pkg::res_t               res,
  output fpt_pkg::ram_req_t           req,
  input  logic [fpt_pkg::ENT_W-1:0]   rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [fpt_pkg::ADDR_W-1:0] clr, clr_next;
  logic [fpt_pkg::NF_W-1:0] nf, nf_next;
  logic [fpt_pkg::TBL_W-1:0] tbl, tbl_next;
  logic [1:0] lvl, lvl_next;
  logic [1:0] st, st_next;
  logic [1:0] op, op_next;
  logic [fpt_pkg::VA_W-1:0] va, va_next, pa, pa_next;
  logic rw, rw_next;

  logic [fpt_pkg::IDX_W-1:0] idx;
  logic [fpt_pkg::ADDR_W-1:0] slot;
  logic [1:0] leaf_lvl;
  logic [fpt_pkg::BASE_W-1:0] leaf_base;
  logic e_p, e_ps;

  always_comb begin
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    case (op)
      fpt_pkg::OP_MAP_1G: leaf_lvl = 2'd1;
      fpt_pkg::OP_MAP_2M: leaf_lvl = 2'd2;
      default:            leaf_lvl = 2'd3;
    endcase
    case (op)
      fpt_pkg::OP_MAP_1G: leaf_base = {18'd0, pa[47:30]};
      fpt_pkg::OP_MAP_2M: leaf_base = {9'd0, pa[47:21]};
      default:            leaf_base = pa[47:12];
    endcase
  end

  assign slot = {tbl, idx};
  assign e_p  = rdata[fpt_pkg::ENT_P];
  assign e_ps = rdata[fpt_pkg::ENT_PS];
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    clr_next   = clr;
    nf_next    = nf;
    tbl_next   = tbl;
    lvl_next   = lvl;
    st_next    = st;
    op_next    = op;
    va_next    = va;
    pa_next    = pa;
    rw_next    = rw;
    req        = '0;
    req.raddr  = slot;
    req.waddr  = slot;
    res.valid  = 1'b0;
    res.status = st;
    unique case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr;
        clr_next  = clr + fpt_pkg::ADDR_W'(1);
        if (&clr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_next    = opcode;
          va_next    = virt_addr;
          pa_next    = phys_addr;
          rw_next    = writable;
          lvl_next   = 2'd0;
          tbl_next   = '0;
          st_next    = fpt_pkg::ST_DONE;
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        state_next = S_DONE;
        if (op == fpt_pkg::OP_UNMAP) begin
          if (lvl == 2'd3 || (lvl != 2'd0 && e_ps)) begin
            req.we = 1'b1;
          end else if (e_p) begin
            tbl_next   = rdata[fpt_pkg::ENT_BASE_LSB +: fpt_pkg::TBL_W];
            lvl_next   = lvl + 2'd1;
            state_next = S_RD;
          end
        end else if (lvl == leaf_lvl) begin
          if (e_p) begin
            st_next = fpt_pkg::ST_REFUSED;
          end else begin
            req.we    = 1'b1;
            req.wdata = {leaf_base, lvl != 2'd3, rw, 1'b1};
          end
        end else if (lvl != 2'd0 && e_ps) begin
          st_next = fpt_pkg::ST_REFUSED;
        end else if (!e_p) begin
          if (nf >= fpt_pkg::NF_W'(fpt_pkg::TABLE_COUNT)) begin
            st_next = fpt_pkg::ST_NO_POOL;
          end else begin
            req.we     = 1'b1;
            req.wdata  = {{(fpt_pkg::BASE_W - fpt_pkg::TBL_W){1'b0}},
                          nf[fpt_pkg::TBL_W-1:0], 1'b0, rw, 1'b1};
            tbl_next   = nf[fpt_pkg::TBL_W-1:0];
            nf_next    = nf + fpt_pkg::NF_W'(1);
            lvl_next   = lvl + 2'd1;
            state_next = S_RD;
          end
        end else begin
          req.we     = 1'b1;
          req.wdata  = rdata | {{(fpt_pkg::ENT_W - 2){1'b0}}, rw, 1'b0};
          tbl_next   = rdata[fpt_pkg::ENT_BASE_LSB +: fpt_pkg::TBL_W];
          lvl_next   = lvl + 2'd1;
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res.valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      nf    <= fpt_pkg::NF_W'(1);
    end else begin
      state <= state_next;
      clr   <= clr_next;
      nf    <= nf_next;
    end
    tbl <= tbl_next;
    lvl <= lvl_next;
    st  <= st_next;
    op  <= op_next;
    va  <= va_next;
    pa  <= pa_next;
    rw  <= rw_next;
  end

endmodule

// ===== sv/fpt_checker.sv =====
`include "four_level_page_table_mapper_defines.svh"

module fpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status
);

  `FPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
  `FPT_ASSERT_SAME(a_status_code, out_valid, status != 2'd3)
  `FPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FPT_ASSERT_RESET(a_reset_quiet, !out_valid && in_stall)

endmodule

bind four_level_page_table_mapper fpt_checker u_fpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status)
);

// ===== bench/four_level_page_table_mapper_tb.sv =====
module four_level_page_table_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class status_board;
    logic [fpt_pkg::ENT_W-1:0] pt_mem [fpt_pkg::DEPTH];
    int unsigned free_tbl;
    logic [1:0] due_status [$];
    int fails;

    function new();
      foreach (pt_mem[i]) pt_mem[i] = '0;
      free_tbl = 1;
      fails = 0;
    endfunction

    function int unsigned slot(int unsigned tbl, logic [8:0] idx);
      return (tbl % fpt_pkg::TABLE_COUNT) * fpt_pkg::ENTRIES + idx;
    endfunction

    function int unsigned child(logic [fpt_pkg::ENT_W-1:0] e);
      return int'(e[38:3] % fpt_pkg::TABLE_COUNT);
    endfunction

    // pass a directory entry; 1 when the pool is exhausted
    function bit walk_dir(int unsigned pos, bit rw, output int unsigned tbl);
      logic [fpt_pkg::ENT_W-1:0] e;
      e = pt_mem[pos];
      if (!e[fpt_pkg::ENT_P]) begin
        if (free_tbl >= fpt_pkg::TABLE_COUNT) return 1;
        e = '0;
        e[fpt_pkg::ENT_P] = 1'b1;
        e[fpt_pkg::ENT_W_BIT] = rw;
        e[38:3] = 36'(free_tbl);
        free_tbl++;
      end else begin
        e[fpt_pkg::ENT_W_BIT] = e[fpt_pkg::ENT_W_BIT] | rw;
      end
      pt_mem[pos] = e;
      tbl = child(e);
      return 0;
    endfunction

    function logic [1:0] map_page(logic [1:0] op, logic [47:0] pa, bit rw,
                                  logic [8:0] i1, i2, i3, i4);
      int unsigned t, pos;
      logic [fpt_pkg::ENT_W-1:0] e;
      if (walk_dir(slot(0, i1), rw, t)) return fpt_pkg::ST_NO_POOL;
      pos = slot(t, i2);
      e = pt_mem[pos];
      if (op == fpt_pkg::OP_MAP_1G) begin
        if (e[fpt_pkg::ENT_P]) return fpt_pkg::ST_REFUSED;
        pt_mem[pos] = {18'd0, pa[47:30], 1'b1, rw, 1'b1};
        return fpt_pkg::ST_DONE;
      end
      if (e[fpt_pkg::ENT_PS]) return fpt_pkg::ST_REFUSED;
      if (walk_dir(pos, rw, t)) return fpt_pkg::ST_NO_POOL;
      pos = slot(t, i3);
      e = pt_mem[pos];
      if (op == fpt_pkg::OP_MAP_2M) begin
        if (e[fpt_pkg::ENT_P]) return fpt_pkg::ST_REFUSED;
        pt_mem[pos] = {9'd0, pa[47:21], 1'b1, rw, 1'b1};
        return fpt_pkg::ST_DONE;
      end
      if (e[fpt_pkg::ENT_PS]) return fpt_pkg::ST_REFUSED;
      if (walk_dir(pos, rw, t)) return fpt_pkg::ST_NO_POOL;
      pos = slot(t, i4);
      if (pt_mem[pos][fpt_pkg::ENT_P]) return fpt_pkg::ST_REFUSED;
      pt_mem[pos] = {pa[47:12], 1'b0, rw, 1'b1};
      return fpt_pkg::ST_DONE;
    endfunction

    function void unmap_page(logic [8:0] i1, i2, i3, i4);
      int unsigned pos;
      logic [fpt_pkg::ENT_W-1:0] e;
      e = pt_mem[slot(0, i1)];
      if (!e[fpt_pkg::ENT_P]) return;
      pos = slot(child(e), i2);
      e = pt_mem[pos];
      if (e[fpt_pkg::ENT_PS]) begin pt_mem[pos] = '0; return; end
      if (!e[fpt_pkg::ENT_P]) return;
      pos = slot(child(e), i3);
      e = pt_mem[pos];
      if (e[fpt_pkg::ENT_PS]) begin pt_mem[pos] = '0; return; end
      if (!e[fpt_pkg::ENT_P]) return;
      pt_mem[slot(child(e), i4)] = '0;
    endfunction

    function void note_item(logic [1:0] op, logic [47:0] va, logic [47:0] pa, bit rw);
      if (op == fpt_pkg::OP_UNMAP) begin
        unmap_page(va[47:39], va[38:30], va[29:21], va[20:12]);
        due_status.push_back(fpt_pkg::ST_DONE);
      end else begin
        due_status.push_back(map_page(op, pa, rw, va[47:39], va[38:30],
                                      va[29:21], va[20:12]));
      end
    endfunction

    function void check_status(logic [1:0] got);
      logic [1:0] want;
      if (due_status.size() == 0) begin
        $error("status %0d with no item pending", got);
        fails++;
        return;
      end
      want = due_status.pop_front();
      if (got !== want) begin
        $error("status: expected %0d, actual %0d", want, got);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, writable;
  logic [1:0] opcode, status;
  logic [47:0] virt_addr, phys_addr;

  status_board board;
  longint unsigned cycles;
  bit hold_long;
  bit sending_done;
  logic [47:0] used_va [$];

  four_level_page_table_mapper dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .virt_addr(virt_addr), .phys_addr(phys_addr),
    .writable(writable), .out_valid(out_valid), .out_stall(out_stall),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(logic [1:0] op, logic [47:0] va, logic [47:0] pa, bit rw);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    virt_addr <= va;
    phys_addr <= pa;
    writable <= rw;
    do @(posedge clk); while (in_stall);
    board.note_item(op, va, pa, rw);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // addresses mostly from a small set of indices so walks share tables
  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    if (used_va.size() > 0 && $urandom_range(0, 2) == 0)
      return used_va[$urandom_range(0, used_va.size() - 1)];
    va = rand48();
    if ($urandom_range(0, 9) != 0) begin
      va[47:39] = 9'($urandom_range(0, 3));
      va[38:30] = 9'($urandom_range(0, 5));
      va[29:21] = 9'($urandom_range(0, 7));
    end
    used_va.push_back(va);
    return va;
  endfunction

  initial begin
    logic [47:0] va;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = fpt_pkg::OP_MAP_4K;
    virt_addr = '0;
    phys_addr = '0;
    writable = 1'b0;
    sending_done = 1'b0;
    hold_long = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(fpt_pkg::OP_UNMAP, '0, '0, 0);
    send_item(fpt_pkg::OP_MAP_4K, '0, '0, 0);
    send_item(fpt_pkg::OP_MAP_4K, '0, '1, 1);
    send_item(fpt_pkg::OP_MAP_2M, 48'h0000_0020_0000, '1, 1);
    send_item(fpt_pkg::OP_MAP_2M, 48'h0000_0000_0000, '1, 1);
    send_item(fpt_pkg::OP_MAP_4K, 48'h0000_0020_1000, '1, 0);
    send_item(fpt_pkg::OP_MAP_1G, 48'h0000_4000_0000, 48'hFFFF_C000_0000, 1);
    send_item(fpt_pkg::OP_MAP_1G, 48'h0000_4000_0000, '0, 0);
    send_item(fpt_pkg::OP_MAP_2M, 48'h0000_4020_0000, '0, 0);
    send_item(fpt_pkg::OP_MAP_4K, 48'h0000_4000_1000, '0, 1);
    send_item(fpt_pkg::OP_UNMAP, 48'h0000_4000_0000, '0, 0);
    send_item(fpt_pkg::OP_MAP_4K, 48'h0000_4000_1000, '0, 1);
    send_item(fpt_pkg::OP_UNMAP, 48'h0000_0020_0000, '0, 0);
    send_item(fpt_pkg::OP_UNMAP, 48'h0000_0000_0000, '0, 0);
    send_item(fpt_pkg::OP_MAP_4K, '1, '1, 1);
    send_item(fpt_pkg::OP_UNMAP, '1, '0, 0);
    send_item(fpt_pkg::OP_UNMAP, 48'h0000_4000_0000, '0, 0);
    send_item(fpt_pkg::OP_MAP_1G, '1, 48'h5555_5555_5555, 0);

    hold_long = 1'b1;
    for (int n = 0; n < 950; n++) begin
      va = pick_va();
      send_item(2'($urandom_range(0, 3)), va, rand48(), 1'($urandom_range(0, 1)));
    end
    // pool is exhausted by now; scatter the roots to keep hitting it
    for (int n = 0; n < 40; n++)
      send_item(2'($urandom_range(0, 2)), rand48(), rand48(),
                1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int gap;
    bit held;
    out_stall = 1'b1;
    held = 1'b0;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (hold_long && !held) begin
        held = 1'b1;
        gap = 300;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_status(status);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (sending_done && board.due_status.size() == 0) begin
        repeat (30) @(posedge clk);
        if (board.fails == 0 && board.due_status.size() == 0)
          $display("[ OK ] regression clean");
        else
          $display("[FAIL] regression broken");
        $finish;
      end
      if (cycles > 400000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/fpt_pkg.sv
sv/fpt_ram.sv
sv/fpt_walk.sv
sv/four_level_page_table_mapper.sv
sv/fpt_checker.sv
bench/four_level_page_table_mapper_tb.sv
